// ===== src/wsmp_pkg.sv =====
`default_nettype none

package wsmp_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_WSM_ID   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHAN_ID  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_ID  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_POWER_ID = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIZE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SCAN = 3'd5;

	// register reset values
	localparam logic [7:0] RST_WSM_ID   = 8'd128;
	localparam logic [7:0] RST_CHAN_ID  = 8'd15;
	localparam logic [7:0] RST_RATE_ID  = 8'd16;
	localparam logic [7:0] RST_POWER_ID = 8'd4;
	localparam logic [7:0] RST_MIN_SIZE = 8'd16;
	localparam logic [7:0] RST_MAX_SCAN = 8'd20;

	// result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_TOO_SHORT = 3'd1;
	localparam logic [2:0] ST_BAD_PSID  = 3'd2;
	localparam logic [2:0] ST_NO_WSM    = 3'd3;
	localparam logic [2:0] ST_TRUNC     = 3'd4;

	// psid prefix masks and patterns
	localparam logic [7:0] PFX4_MASK = 8'hF0;
	localparam logic [7:0] PFX4_VAL  = 8'hE0;
	localparam logic [7:0] PFX3_MASK = 8'hE0;
	localparam logic [7:0] PFX3_VAL  = 8'hC0;
	localparam logic [7:0] PFX2_MASK = 8'hC0;
	localparam logic [7:0] PFX2_VAL  = 8'h80;
	localparam logic [7:0] PFX1_MASK = 8'h80;
	localparam logic [7:0] PFX1_VAL  = 8'h00;

	typedef enum logic [6:0] {
		PH_IDLE = 7'b0000001,
		PH_PSID = 7'b0000010,
		PH_SCAN = 7'b0000100,
		PH_ELEN = 7'b0001000,
		PH_EVAL = 7'b0010000,
		PH_PHI  = 7'b0100000,
		PH_PLO  = 7'b1000000
	} wsmp_phase_t;

	typedef enum logic [1:0] {
		EL_NONE = 2'd0,
		EL_CHAN = 2'd1,
		EL_RATE = 2'd2,
		EL_POW  = 2'd3
	} wsmp_elem_t;

	typedef struct packed {
		logic [7:0] wsm_id;
		logic [7:0] chan_id;
		logic [7:0] rate_id;
		logic [7:0] power_id;
		logic [7:0] min_frame_size;
		logic [7:0] max_scan_offset;
	} wsmp_cfg_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        frame_start;
		logic [15:0] frame_size;
	} wsmp_byte_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [7:0]        header_length;
		logic [7:0]        version;
		logic [2:0]        psid_length;
		logic [31:0]       psid;
		logic [7:0]        channel;
		logic [7:0]        rate;
		logic signed [7:0] tx_power;
		logic [15:0]       payload_length;
	} wsmp_result_t;

	// psid length from the prefix bits of its first byte, zero if invalid
	function automatic logic [2:0] prefix_len(input logic [7:0] b);
		logic [2:0] n;
		if ((b & PFX4_MASK) == PFX4_VAL) n = 3'd4;
		else if ((b & PFX3_MASK) == PFX3_VAL) n = 3'd3;
		else if ((b & PFX2_MASK) == PFX2_VAL) n = 3'd2;
		else if ((b & PFX1_MASK) == PFX1_VAL) n = 3'd1;
		else n = 3'd0;
		return n;
	endfunction

endpackage

`default_nettype wire

// ===== src/wsmp_if.sv =====
`default_nettype none

interface wsmp_byte_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        frame_start;
	logic [15:0] frame_size;

	modport source (output valid, data_byte, frame_start, frame_size, input ready);
	modport sink (input valid, data_byte, frame_start, frame_size, output ready);
endinterface

interface wsmp_hdr_if;
	logic              valid;
	logic              ready;
	logic [2:0]        status;
	logic [7:0]        header_length;
	logic [7:0]        version;
	logic [2:0]        psid_length;
	logic [31:0]       psid;
	logic [7:0]        channel;
	logic [7:0]        rate;
	logic signed [7:0] tx_power;
	logic [15:0]       payload_length;

	modport source (output valid, status, header_length, version, psid_length, psid,
		channel, rate, tx_power, payload_length, input ready);
	modport sink (input valid, status, header_length, version, psid_length, psid,
		channel, rate, tx_power, payload_length, output ready);
endinterface

interface wsmp_cfg_if import wsmp_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [7:0]           data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/wsmp_cfg_regs.sv =====
`default_nettype none

module wsmp_cfg_regs import wsmp_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	wsmp_cfg_if.sink   cfg,
	output wsmp_cfg_t  regs
);

	wsmp_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.wsm_id          <= RST_WSM_ID;
			regs_q.chan_id         <= RST_CHAN_ID;
			regs_q.rate_id         <= RST_RATE_ID;
			regs_q.power_id        <= RST_POWER_ID;
			regs_q.min_frame_size  <= RST_MIN_SIZE;
			regs_q.max_scan_offset <= RST_MAX_SCAN;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_WSM_ID:   regs_q.wsm_id          <= cfg.data;
				CFG_CHAN_ID:  regs_q.chan_id         <= cfg.data;
				CFG_RATE_ID:  regs_q.rate_id         <= cfg.data;
				CFG_POWER_ID: regs_q.power_id        <= cfg.data;
				CFG_MIN_SIZE: regs_q.min_frame_size  <= cfg.data;
				CFG_MAX_SCAN: regs_q.max_scan_offset <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== src/wsmp_frame_fsm.sv =====
`default_nettype none

module wsmp_frame_fsm import wsmp_pkg::*; #(
	parameter int MAX_PSID_BYTES = 4
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wsmp_cfg_t    cfg,
	input  wire          step,
	input  wsmp_byte_t   item,
	output logic         res_valid,
	output wsmp_result_t res
);

	wsmp_phase_t phase_q, phase_d;
	wsmp_elem_t  pend_q, pend_d;
	logic [7:0]  offset_q, offset_d;
	logic [15:0] size_q, size_d;
	logic [2:0]  left_q, left_d;
	logic [2:0]  len_q, len_d;
	logic [31:0] acc_q, acc_d;
	logic [7:0]  version_q, version_d;
	logic [7:0]  chan_q, chan_d;
	logic [7:0]  rate_q, rate_d;
	logic [7:0]  power_q, power_d;
	logic [7:0]  lhigh_q, lhigh_d;

	logic [8:0]  off_inc;
	logic        trunc, limit, go_adv, go_scan, emit;
	logic [2:0]  st, n;
	logic [7:0]  hlen, b;
	logic [15:0] plen;

	assign b       = item.data_byte;
	assign off_inc = {1'b0, offset_q} + 9'd1;
	// no next byte in the frame, or next byte offset past 255
	assign trunc   = ({7'd0, off_inc} >= size_q) || off_inc[8];
	assign limit   = ({7'd0, off_inc} >= size_q) || (off_inc > {1'b0, cfg.max_scan_offset});

	always_comb begin
		phase_d   = phase_q;
		pend_d    = pend_q;
		offset_d  = offset_q;
		size_d    = size_q;
		left_d    = left_q;
		len_d     = len_q;
		acc_d     = acc_q;
		version_d = version_q;
		chan_d    = chan_q;
		rate_d    = rate_q;
		power_d   = power_q;
		lhigh_d   = lhigh_q;
		emit      = 1'b0;
		st        = ST_OK;
		hlen      = '0;
		plen      = '0;
		go_adv    = 1'b0;
		go_scan   = 1'b0;
		n         = prefix_len(b);
		if (step) begin
			if (item.frame_start) begin
				phase_d   = PH_IDLE;
				pend_d    = EL_NONE;
				offset_d  = '0;
				left_d    = '0;
				len_d     = '0;
				acc_d     = '0;
				version_d = '0;
				chan_d    = '0;
				rate_d    = '0;
				power_d   = '0;
				lhigh_d   = '0;
				size_d    = item.frame_size;
				if (item.frame_size < {8'd0, cfg.min_frame_size}) begin
					emit = 1'b1;
					st   = ST_TOO_SHORT;
				end else if (item.frame_size == '0) begin
					emit = 1'b1;
					st   = ST_TRUNC;
				end else begin
					version_d = b;
					phase_d   = PH_PSID;
					if (item.frame_size <= 16'd1) begin
						emit = 1'b1;
						st   = ST_TRUNC;
					end else begin
						offset_d = 8'd1;
					end
				end
			end else begin
				unique case (phase_q)
					PH_PSID: begin
						if (len_q == '0) begin
							if (n == '0 || int'(n) > MAX_PSID_BYTES) begin
								emit = 1'b1;
								st   = ST_BAD_PSID;
							end else begin
								len_d  = n;
								left_d = n - 3'd1;
								acc_d  = {24'd0, b};
							end
						end else begin
							acc_d  = {acc_q[23:0], b};
							left_d = left_q - 3'd1;
						end
						if (!emit) begin
							if (left_d == '0) phase_d = PH_SCAN;
							go_adv = 1'b1;
						end
					end
					PH_SCAN: begin
						// wsm id wins over channel, channel over rate, rate over power
						priority if (b == cfg.wsm_id) begin
							phase_d = PH_PHI;
							go_adv  = 1'b1;
						end else if (b == cfg.chan_id) begin
							pend_d  = EL_CHAN;
							phase_d = PH_ELEN;
							go_adv  = 1'b1;
						end else if (b == cfg.rate_id) begin
							pend_d  = EL_RATE;
							phase_d = PH_ELEN;
							go_adv  = 1'b1;
						end else if (b == cfg.power_id) begin
							pend_d  = EL_POW;
							phase_d = PH_ELEN;
							go_adv  = 1'b1;
						end else begin
							go_scan = 1'b1;
						end
					end
					PH_ELEN: begin
						phase_d = PH_EVAL;
						go_adv  = 1'b1;
					end
					PH_EVAL: begin
						unique case (pend_q)
							EL_CHAN: chan_d  = b;
							EL_RATE: rate_d  = b;
							EL_POW:  power_d = b;
							default: ;
						endcase
						pend_d  = EL_NONE;
						go_scan = 1'b1;
					end
					PH_PHI: begin
						lhigh_d = b;
						if (({7'd0, off_inc} >= size_q) || (off_inc >= 9'd255)) begin
							emit = 1'b1;
							st   = ST_TRUNC;
						end else begin
							phase_d  = PH_PLO;
							offset_d = off_inc[7:0];
						end
					end
					PH_PLO: begin
						emit = 1'b1;
						st   = ST_OK;
						hlen = off_inc[7:0];
						plen = {lhigh_q, b};
					end
					default: ;
				endcase
				if (go_scan) begin
					if (limit) begin
						emit = 1'b1;
						st   = ST_NO_WSM;
					end else begin
						phase_d = PH_SCAN;
						go_adv  = 1'b1;
					end
				end
				if (go_adv) begin
					if (trunc) begin
						emit = 1'b1;
						st   = ST_TRUNC;
					end else begin
						offset_d = off_inc[7:0];
					end
				end
			end
			if (emit) phase_d = PH_IDLE;
		end
	end

	assign res_valid          = step && emit;
	assign res.status         = st;
	assign res.header_length  = hlen;
	assign res.version        = version_d;
	assign res.psid_length    = len_d;
	assign res.psid           = acc_d;
	assign res.channel        = chan_d;
	assign res.rate           = rate_d;
	assign res.tx_power       = $signed(power_d);
	assign res.payload_length = plen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			pend_q    <= EL_NONE;
			offset_q  <= '0;
			size_q    <= '0;
			left_q    <= '0;
			len_q     <= '0;
			acc_q     <= '0;
			version_q <= '0;
			chan_q    <= '0;
			rate_q    <= '0;
			power_q   <= '0;
			lhigh_q   <= '0;
		end else begin
			phase_q   <= phase_d;
			pend_q    <= pend_d;
			offset_q  <= offset_d;
			size_q    <= size_d;
			left_q    <= left_d;
			len_q     <= len_d;
			acc_q     <= acc_d;
			version_q <= version_d;
			chan_q    <= chan_d;
			rate_q    <= rate_d;
			power_q   <= power_d;
			lhigh_q   <= lhigh_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/wsmp_out_buf.sv =====
`default_nettype none

module wsmp_out_buf import wsmp_pkg::*; (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          push,
	input  wsmp_result_t push_data,
	output logic         full,
	wsmp_hdr_if.source   hdr
);

	logic [1:0]   count_q;
	wsmp_result_t head_q, tail_q;
	logic         pop;

	assign pop  = hdr.valid && hdr.ready;
	assign full = (count_q == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (push && count_q == 2'd1) begin
				head_q <= push_data;
			end else begin
				head_q <= tail_q;
			end
			if (push && count_q == 2'd2) tail_q <= push_data;
		end else if (push) begin
			if (count_q == 2'd0) begin
				head_q <= push_data;
			end else begin
				tail_q <= push_data;
			end
		end
	end

	assign hdr.valid          = (count_q != 2'd0);
	assign hdr.status         = head_q.status;
	assign hdr.header_length  = head_q.header_length;
	assign hdr.version        = head_q.version;
	assign hdr.psid_length    = head_q.psid_length;
	assign hdr.psid           = head_q.psid;
	assign hdr.channel        = head_q.channel;
	assign hdr.rate           = head_q.rate;
	assign hdr.tx_power       = head_q.tx_power;
	assign hdr.payload_length = head_q.payload_length;

endmodule

`default_nettype wire

// ===== src/wsmp_header_parser_unit.sv =====
// channel  role    payload                                    transfer when
// frame    sink    data_byte, frame_start, frame_size         frame.valid & frame.ready
// hdr      source  status, header_length, version, psid_*,    hdr.valid & hdr.ready
//                  channel, rate, tx_power, payload_length
// cfg      sink    index, data                                cfg.valid & cfg.ready
//
// one frame byte per cycle while the output buffer has room; a result passes the input register
// that holds the byte ending the header, then the parser state update into the output buffer
// arst_n clears the parser to idle, empties both registers and loads register defaults
// frame.ready drops only while the two-entry output buffer is full and a byte is held
// cfg.ready is always high; writes are expected only while the block is idle
`default_nettype none

module wsmp_header_parser_unit import wsmp_pkg::*; #(
	parameter int MAX_PSID_BYTES = 4
) (
	input  wire        clk,
	input  wire        arst_n,
	wsmp_byte_if.sink  frame,
	wsmp_hdr_if.source hdr,
	wsmp_cfg_if.sink   cfg
);

	// configuration registers
	wsmp_cfg_t    cfg_regs;

	// input register stage
	wsmp_byte_t   item_s1;
	logic         valid_s1;

	logic         buf_full;
	logic         step;
	logic         res_valid;
	wsmp_result_t res;
	logic         take;

	// a held byte moves into the parser whenever the buffer has room for a result
	assign step        = valid_s1 && !buf_full;
	assign frame.ready = !valid_s1 || !buf_full;
	assign take        = frame.valid && frame.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	// byte payload, no reset needed
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.data_byte   <= frame.data_byte;
			item_s1.frame_start <= frame.frame_start;
			item_s1.frame_size  <= frame.frame_size;
		end
	end

	wsmp_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (cfg_regs)
	);

	// per-byte parse state: version, psid, element scan, payload length
	wsmp_frame_fsm #(
		.MAX_PSID_BYTES (MAX_PSID_BYTES)
	) u_frame_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_regs),
		.step      (step),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// result buffer decouples hdr.ready from frame.ready
	wsmp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.full      (buf_full),
		.hdr       (hdr)
	);

endmodule

`default_nettype wire

// ===== src/wsmp_checker.sv =====
`default_nettype none

module wsmp_checker import wsmp_pkg::*; (
	input wire        clk,
	input wire        arst_n,
	input wire        out_valid,
	input wire        out_ready,
	input wire [2:0]  status,
	input wire [7:0]  header_length,
	input wire [7:0]  version,
	input wire [2:0]  psid_length,
	input wire [31:0] psid,
	input wire [15:0] payload_length
);

	// a stalled result keeps its status
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> header_length == 8'd0 && payload_length == 16'd0)
		else $error("error result with nonzero lengths");

	a_short: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_TOO_SHORT |->
			version == 8'd0 && psid == 32'd0 && psid_length == 3'd0)
		else $error("short frame result carries parsed fields");

	a_bad_psid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_BAD_PSID |-> psid_length == 3'd0 && psid == 32'd0)
		else $error("bad psid result carries a psid");

	// version, psid, wsm id and two length bytes all lie inside the header
	a_ok_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |->
			psid_length != 3'd0 && header_length >= {5'd0, psid_length} + 8'd4)
		else $error("ok result with short header");

endmodule

bind wsmp_header_parser_unit wsmp_checker u_wsmp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (hdr.valid),
	.out_ready      (hdr.ready),
	.status         (hdr.status),
	.header_length  (hdr.header_length),
	.version        (hdr.version),
	.psid_length    (hdr.psid_length),
	.psid           (hdr.psid),
	.payload_length (hdr.payload_length)
);

`default_nettype wire

// ===== verif/tb.sv =====
`default_nettype none

module tb;
	import wsmp_pkg::*;

	localparam int PSID_MAX   = 4;
	localparam int RUN_LIMIT  = 200000;
	localparam int PHASE_BYTES = 100;

	// one byte offered to the parser, with an optional hand-written result
	typedef struct packed {
		wsmp_byte_t   b;
		logic         chk;
		wsmp_result_t r;
	} feed_t;

	localparam wsmp_result_t NO_HDR        = '0;
	localparam wsmp_result_t TOO_SHORT_HDR = '{status: ST_TOO_SHORT, default: '0};
	localparam wsmp_result_t BAD_PSID_HDR  = '{status: ST_BAD_PSID, default: '0};

	logic clk;
	logic arst_n;

	wsmp_byte_if frame_bus();
	wsmp_hdr_if  hdr_bus();
	wsmp_cfg_if  cfg_bus();

	wsmp_header_parser_unit #(
		.MAX_PSID_BYTES(PSID_MAX)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.frame (frame_bus),
		.hdr   (hdr_bus),
		.cfg   (cfg_bus)
	);

	// directed bytes under reset register values
	// results are typed in only for the obvious error cases
	feed_t dir_tab [28] = '{
		// size below the minimum: rejected on the first byte
		'{'{8'hAA, 1'b1, 16'd15}, 1'b1, TOO_SHORT_HDR},
		// stray byte while idle, ignored
		'{'{8'h7E, 1'b0, 16'hFFFF}, 1'b0, NO_HDR},
		// full header: four-byte psid, channel, rate and power elements, wsm id
		'{'{8'hFF, 1'b1, 16'hFFFF}, 1'b0, NO_HDR},
		'{'{8'hE1, 1'b0, 16'h0000}, 1'b0, NO_HDR},
		'{'{8'h23, 1'b0, 16'hFFFF}, 1'b0, NO_HDR},
		'{'{8'h45, 1'b0, 16'h0000}, 1'b0, NO_HDR},
		'{'{8'h67, 1'b0, 16'hFFFF}, 1'b0, NO_HDR},
		'{'{8'h0F, 1'b0, 16'h0000}, 1'b0, NO_HDR},
		'{'{8'h01, 1'b0, 16'hFFFF}, 1'b0, NO_HDR},
		'{'{8'hAB, 1'b0, 16'h0000}, 1'b0, NO_HDR},
		'{'{8'h10, 1'b0, 16'hFFFF}, 1'b0, NO_HDR},
		'{'{8'h01, 1'b0, 16'h0000}, 1'b0, NO_HDR},
		'{'{8'hCD, 1'b0, 16'hFFFF}, 1'b0, NO_HDR},
		'{'{8'h04, 1'b0, 16'h0000}, 1'b0, NO_HDR},
		'{'{8'h01, 1'b0, 16'hFFFF}, 1'b0, NO_HDR},
		'{'{8'h80, 1'b0, 16'h0000}, 1'b0, NO_HDR},
		'{'{8'h80, 1'b0, 16'hFFFF}, 1'b0, NO_HDR},
		'{'{8'hFF, 1'b0, 16'h0000}, 1'b0, NO_HDR},
		'{'{8'hFF, 1'b0, 16'hFFFF}, 1'b0, NO_HDR},
		// psid prefix 1111: bad prefix, version zero here
		'{'{8'h00, 1'b1, 16'd16}, 1'b0, NO_HDR},
		'{'{8'hF5, 1'b0, 16'h0000}, 1'b1, BAD_PSID_HDR},
		// frame dropped by a new frame start in the middle of its psid
		'{'{8'h3C, 1'b1, 16'd100}, 1'b0, NO_HDR},
		'{'{8'h80, 1'b0, 16'h0000}, 1'b0, NO_HDR},
		// shortest good header: one-byte psid, wsm id right away
		'{'{8'h01, 1'b1, 16'd16}, 1'b0, NO_HDR},
		'{'{8'h05, 1'b0, 16'h0000}, 1'b0, NO_HDR},
		'{'{8'h80, 1'b0, 16'h0000}, 1'b0, NO_HDR},
		'{'{8'h12, 1'b0, 16'h0000}, 1'b0, NO_HDR},
		'{'{8'h34, 1'b0, 16'h0000}, 1'b0, NO_HDR}
	};

	// parser shadow state and register copy
	wsmp_cfg_t   cur_cfg;
	wsmp_phase_t hdr_phase;
	wsmp_elem_t  hdr_pend;
	logic [7:0]  hdr_off;
	logic [15:0] hdr_size;
	logic [7:0]  hdr_ver;
	logic [2:0]  psid_left;
	logic [2:0]  psid_len;
	logic [31:0] psid_acc;
	logic [7:0]  hdr_chan;
	logic [7:0]  hdr_rate;
	logic [7:0]  hdr_pow;
	logic [7:0]  hdr_len_hi;

	feed_t        send_q[$];
	wsmp_result_t hdr_expect_q[$];
	feed_t        cur_job;
	wsmp_result_t pred_r;
	wsmp_result_t seen_r;
	bit           pred_hit;
	bit           byte_took;
	bit           hold_off;
	int           bytes_in;
	int           err_cnt;
	int           cycle_cnt;
	int           burst_left;
	int           gap_left;
	int           stall_mode;
	int           stall_cnt;

	// clock, period 8
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic flag_err(input string what, input logic [31:0] got, input logic [31:0] want);
		err_cnt++;
		if (err_cnt <= 50)
			$display("[%0d] mismatch %s: got %0h want %0h", cycle_cnt, what, got, want);
	endtask

	task automatic check_hdr(input wsmp_result_t g, input wsmp_result_t w);
		if (g.status !== w.status) flag_err("status", g.status, w.status);
		if (g.header_length !== w.header_length)
			flag_err("header_length", g.header_length, w.header_length);
		if (g.version !== w.version) flag_err("version", g.version, w.version);
		if (g.psid_length !== w.psid_length) flag_err("psid_length", g.psid_length, w.psid_length);
		if (g.psid !== w.psid) flag_err("psid", g.psid, w.psid);
		if (g.channel !== w.channel) flag_err("channel", g.channel, w.channel);
		if (g.rate !== w.rate) flag_err("rate", g.rate, w.rate);
		if (g.tx_power[7:0] !== w.tx_power[7:0])
			flag_err("tx_power", g.tx_power[7:0], w.tx_power[7:0]);
		if (g.payload_length !== w.payload_length)
			flag_err("payload_length", g.payload_length, w.payload_length);
	endtask

	// ------------------------------------------------------------------
	// header predictor
	// ------------------------------------------------------------------

	function automatic void clear_hdr();
		hdr_phase  = PH_IDLE;
		hdr_pend   = EL_NONE;
		hdr_off    = '0;
		hdr_size   = '0;
		hdr_ver    = '0;
		psid_left  = '0;
		psid_len   = '0;
		psid_acc   = '0;
		hdr_chan   = '0;
		hdr_rate   = '0;
		hdr_pow    = '0;
		hdr_len_hi = '0;
	endfunction

	// psid byte count from its leading prefix bits, zero when none fits
	function automatic logic [2:0] psid_width(input logic [7:0] b);
		casez (b)
			8'b0???????: return 3'd1;
			8'b10??????: return 3'd2;
			8'b110?????: return 3'd3;
			8'b1110????: return 3'd4;
			default:     return 3'd0;
		endcase
	endfunction

	// build a result from what has been parsed so far; parser goes idle
	function automatic bit close_hdr(input logic [2:0] st, input int hlen, input int plen,
			output wsmp_result_t r);
		r.status         = st;
		r.header_length  = hlen[7:0];
		r.version        = hdr_ver;
		r.psid_length    = psid_len;
		r.psid           = psid_acc;
		r.channel        = hdr_chan;
		r.rate           = hdr_rate;
		r.tx_power       = hdr_pow;
		r.payload_length = plen[15:0];
		hdr_phase = PH_IDLE;
		return 1'b1;
	endfunction

	// step to the next byte, truncated if it lies past the frame or offset 255
	function automatic bit next_pos(input int o, output wsmp_result_t r);
		r = '0;
		if (o + 1 >= hdr_size || o + 1 > 255)
			return close_hdr(ST_TRUNC, 0, 0, r);
		hdr_off = o[7:0] + 8'd1;
		return 1'b0;
	endfunction

	// end of one scan position: give up at frame end or past the scan limit
	function automatic bit next_elem(input int o, output wsmp_result_t r);
		r = '0;
		if (o + 1 >= hdr_size || o + 1 > cur_cfg.max_scan_offset)
			return close_hdr(ST_NO_WSM, 0, 0, r);
		hdr_phase = PH_SCAN;
		return next_pos(o, r);
	endfunction

	// one accepted byte; returns 1 when it completes a result
	function automatic bit parse_byte(input wsmp_byte_t it, output wsmp_result_t r);
		logic [7:0] b;
		logic [2:0] n;
		int         o;
		b = it.data_byte;
		o = hdr_off;
		r = '0;
		// a frame start always restarts, dropping any frame in progress
		if (it.frame_start) begin
			clear_hdr();
			hdr_size = it.frame_size;
			if (hdr_size < cur_cfg.min_frame_size)
				return close_hdr(ST_TOO_SHORT, 0, 0, r);
			if (hdr_size == 16'd0)
				return close_hdr(ST_TRUNC, 0, 0, r);
			hdr_ver   = b;
			hdr_phase = PH_PSID;
			return next_pos(0, r);
		end
		case (hdr_phase)
			PH_PSID: begin
				if (psid_len == 3'd0) begin
					n = psid_width(b);
					if (n == 3'd0 || n > PSID_MAX)
						return close_hdr(ST_BAD_PSID, 0, 0, r);
					psid_len  = n;
					psid_left = n - 3'd1;
					psid_acc  = {24'd0, b};
				end else begin
					psid_acc  = {psid_acc[23:0], b};
					psid_left = psid_left - 3'd1;
				end
				if (psid_left == 3'd0)
					hdr_phase = PH_SCAN;
				return next_pos(o, r);
			end
			PH_SCAN: begin
				// wsm id wins, then channel, then rate, then power
				if (b == cur_cfg.wsm_id) begin
					hdr_phase = PH_PHI;
					return next_pos(o, r);
				end
				if (b == cur_cfg.chan_id) hdr_pend = EL_CHAN;
				else if (b == cur_cfg.rate_id) hdr_pend = EL_RATE;
				else if (b == cur_cfg.power_id) hdr_pend = EL_POW;
				else return next_elem(o, r);
				hdr_phase = PH_ELEN;
				return next_pos(o, r);
			end
			PH_ELEN: begin
				// element length byte is skipped
				hdr_phase = PH_EVAL;
				return next_pos(o, r);
			end
			PH_EVAL: begin
				case (hdr_pend)
					EL_CHAN: hdr_chan = b;
					EL_RATE: hdr_rate = b;
					EL_POW:  hdr_pow  = b;
					default: ;
				endcase
				hdr_pend = EL_NONE;
				return next_elem(o, r);
			end
			PH_PHI: begin
				hdr_len_hi = b;
				if (o + 1 >= hdr_size || o + 1 >= 255)
					return close_hdr(ST_TRUNC, 0, 0, r);
				hdr_phase = PH_PLO;
				hdr_off   = o[7:0] + 8'd1;
				return 1'b0;
			end
			PH_PLO:
				return close_hdr(ST_OK, o + 1, {hdr_len_hi, b}, r);
			default:
				return 1'b0;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// stimulus builders
	// ------------------------------------------------------------------

	task automatic push_byte(input logic [7:0] d, input logic s, input logic [15:0] sz);
		feed_t j;
		j.b   = '{d, s, sz};
		j.chk = 1'b0;
		j.r   = NO_HDR;
		send_q.push_back(j);
	endtask

	// one random frame: mostly well formed, some cut short, bad prefixes and noise
	task automatic queue_frame();
		logic [7:0]  fb[$];
		logic [7:0]  eid;
		logic [15:0] sz;
		int          kind, np, k, need, cut, m;
		kind = $urandom_range(0, 99);
		// noise: loose bytes with no frame start
		if (kind >= 85) begin
			repeat ($urandom_range(1, 6)) push_byte(8'($urandom), 1'b0, 16'($urandom));
			return;
		end
		fb.push_back(8'($urandom));
		if (kind >= 78) begin
			// prefix 1111 is never a valid psid length
			fb.push_back({4'b1111, 4'($urandom)});
		end else begin
			np = $urandom_range(1, 4);
			case (np)
				1:       fb.push_back({1'b0, 7'($urandom)});
				2:       fb.push_back({2'b10, 6'($urandom)});
				3:       fb.push_back({3'b110, 5'($urandom)});
				default: fb.push_back({4'b1110, 4'($urandom)});
			endcase
			repeat (np - 1) fb.push_back(8'($urandom));
			// a few elements, known ones carry length and value
			repeat ($urandom_range(0, 4)) begin
				k = $urandom_range(0, 3);
				case (k)
					0:       eid = cur_cfg.chan_id;
					1:       eid = cur_cfg.rate_id;
					2:       eid = cur_cfg.power_id;
					default: eid = 8'($urandom);
				endcase
				fb.push_back(eid);
				if (k != 3) begin
					fb.push_back(8'($urandom));
					fb.push_back(8'($urandom));
				end
			end
			fb.push_back(cur_cfg.wsm_id);
			fb.push_back(8'($urandom));
			fb.push_back(8'($urandom));
		end
		need = fb.size();
		m    = cur_cfg.min_frame_size;
		case ($urandom_range(0, 9))
			0, 1:    sz = 16'($urandom);
			2:       sz = 16'($urandom_range(0, need));
			default: sz = 16'(((need > m) ? need : m) + $urandom_range(0, 20));
		endcase
		if (kind >= 70 && kind < 78) begin
			// abandoned part way, the next frame start drops it
			cut = $urandom_range(1, need - 1);
		end else begin
			repeat ($urandom_range(0, 2)) fb.push_back(8'($urandom));
			cut = fb.size();
		end
		for (k = 0; k < cut; k++)
			push_byte(fb[k], k == 0, (k == 0) ? sz : 16'($urandom));
	endtask

	// long scan of filler bytes toward the 255 byte header limit
	task automatic queue_long();
		logic [7:0] f;
		int         fill;
		fill = $urandom_range(249, 253);
		push_byte(8'($urandom), 1'b1, 16'hFFFF);
		push_byte({1'b0, 7'($urandom)}, 1'b0, 16'($urandom));
		repeat (fill) begin
			f = 8'($urandom);
			while (f == cur_cfg.wsm_id || f == cur_cfg.chan_id || f == cur_cfg.rate_id ||
					f == cur_cfg.power_id)
				f = 8'($urandom);
			push_byte(f, 1'b0, 16'($urandom));
		end
		push_byte(cur_cfg.wsm_id, 1'b0, 16'($urandom));
		push_byte(8'($urandom), 1'b0, 16'($urandom));
		push_byte(8'($urandom), 1'b0, 16'($urandom));
	endtask

	// random frames, closed by a zero-size frame that always yields a result
	task automatic fill_phase();
		int stop_at;
		stop_at = send_q.size() + PHASE_BYTES;
		while (send_q.size() < stop_at) queue_frame();
		push_byte(8'($urandom), 1'b1, 16'd0);
	endtask

	// wait until every byte is taken and every result has come back
	task automatic drain();
		int waited;
		waited = 0;
		while (send_q.size() != 0 || frame_bus.valid) @(posedge clk);
		while (hdr_expect_q.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		// leave a margin after the last result
		repeat (8) @(posedge clk);
	endtask

	// one register write transfer, shadow copy updated on acceptance
	task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] v);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= v;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		case (idx)
			CFG_WSM_ID:   cur_cfg.wsm_id          = v;
			CFG_CHAN_ID:  cur_cfg.chan_id         = v;
			CFG_RATE_ID:  cur_cfg.rate_id         = v;
			CFG_POWER_ID: cur_cfg.power_id        = v;
			CFG_MIN_SIZE: cur_cfg.min_frame_size  = v;
			CFG_MAX_SCAN: cur_cfg.max_scan_offset = v;
			default: ;
		endcase
	endtask

	task automatic program_regs(input wsmp_cfg_t c);
		cfg_put(CFG_WSM_ID, c.wsm_id);
		cfg_put(CFG_CHAN_ID, c.chan_id);
		cfg_put(CFG_RATE_ID, c.rate_id);
		cfg_put(CFG_POWER_ID, c.power_id);
		cfg_put(CFG_MIN_SIZE, c.min_frame_size);
		cfg_put(CFG_MAX_SCAN, c.max_scan_offset);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// frame sender: bursts of random length, random gaps in between
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			frame_bus.valid <= 1'b0;
		end else if (!frame_bus.valid || byte_took) begin
			if (gap_left != 0) begin
				gap_left--;
				frame_bus.valid <= 1'b0;
			end else if (send_q.size() != 0) begin
				cur_job = send_q.pop_front();
				frame_bus.valid       <= 1'b1;
				frame_bus.data_byte   <= cur_job.b.data_byte;
				frame_bus.frame_start <= cur_job.b.frame_start;
				frame_bus.frame_size  <= cur_job.b.frame_size;
				if (burst_left <= 1) begin
					// now and then a long burst with no gaps at all
					burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) :
						$urandom_range(1, 12);
					gap_left = $urandom_range(0, 7);
				end else begin
					burst_left--;
				end
			end else begin
				frame_bus.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// result receiver: stall pattern switches at random among four modes
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			hdr_bus.ready <= 1'b0;
		end else begin
			if (stall_cnt == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_cnt  = $urandom_range(20, 120);
			end else begin
				stall_cnt--;
			end
			if (hold_off)
				hdr_bus.ready <= 1'b0;
			else case (stall_mode)
				0:       hdr_bus.ready <= 1'b1;
				1:       hdr_bus.ready <= 1'($urandom_range(0, 1));
				2:       hdr_bus.ready <= ($urandom_range(0, 3) == 0);
				default: hdr_bus.ready <= (stall_cnt % 3 != 0);
			endcase
		end
	end

	// long hold-off in the middle of the first run of short random frames,
	// so results pile up, the output buffer fills and the parser pushes back
	initial begin
		hold_off = 1'b0;
		while (!(bytes_in > 60 && send_q.size() > 40)) @(posedge clk);
		hold_off = 1'b1;
		repeat (300) @(posedge clk);
		hold_off = 1'b0;
	end

	// ------------------------------------------------------------------
	// transfer monitor: predict on every byte taken, check every result
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			byte_took = 1'b0;
		end else begin
			byte_took = frame_bus.valid && frame_bus.ready;
			if (byte_took) begin
				bytes_in++;
				pred_hit = parse_byte(cur_job.b, pred_r);
				if (cur_job.chk)
					hdr_expect_q.push_back(cur_job.r);
				else if (pred_hit)
					hdr_expect_q.push_back(pred_r);
			end
			if (hdr_bus.valid && hdr_bus.ready) begin
				seen_r = '{hdr_bus.status, hdr_bus.header_length, hdr_bus.version,
					hdr_bus.psid_length, hdr_bus.psid, hdr_bus.channel, hdr_bus.rate,
					hdr_bus.tx_power, hdr_bus.payload_length};
				if (hdr_expect_q.size() == 0)
					flag_err("result with nothing pending", seen_r.status, 3'd0);
				else
					check_hdr(seen_r, hdr_expect_q.pop_front());
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > RUN_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		wsmp_cfg_t regs;
		int        i, ph;
		// every input known from time zero
		arst_n                = 1'b0;
		frame_bus.valid       = 1'b0;
		frame_bus.data_byte   = '0;
		frame_bus.frame_start = 1'b0;
		frame_bus.frame_size  = '0;
		hdr_bus.ready         = 1'b0;
		cfg_bus.valid         = 1'b0;
		cfg_bus.index         = '0;
		cfg_bus.data          = '0;
		bytes_in   = 0;
		err_cnt    = 0;
		cycle_cnt  = 0;
		burst_left = 1;
		gap_left   = 0;
		stall_mode = 0;
		stall_cnt  = 0;
		cur_job    = '0;
		cur_cfg    = '{RST_WSM_ID, RST_CHAN_ID, RST_RATE_ID, RST_POWER_ID,
			RST_MIN_SIZE, RST_MAX_SCAN};
		clear_hdr();

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table under reset values
		for (i = 0; i < 28; i++) send_q.push_back(dir_tab[i]);
		drain();

		// random frames under reset values
		fill_phase();
		drain();

		// register settings: extremes, coinciding ids, then random ones
		for (ph = 1; ph <= 5; ph++) begin
			case (ph)
				// widest scan, no minimum size
				1: regs = '{8'h00, 8'hFF, 8'h01, 8'hFE, 8'h00, 8'hFF};
				// largest minimum, scan limit of one, channel shadows rate and power
				2: regs = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h01};
				// wsm shadows channel, rate shadows power
				3: regs = '{8'h55, 8'h55, 8'hAA, 8'hAA, 8'h01, 8'h08};
				default: regs = '{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom_range(0, 40)), 8'($urandom_range(1, 255))};
			endcase
			program_regs(regs);
			if (ph == 1) begin
				queue_long();
				queue_long();
			end
			fill_phase();
			drain();
		end

		if (hdr_expect_q.size() != 0)
			flag_err("results never arrived", hdr_expect_q.size(), 0);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
src/wsmp_pkg.sv
src/wsmp_if.sv
src/wsmp_cfg_regs.sv
src/wsmp_frame_fsm.sv
src/wsmp_out_buf.sv
src/wsmp_header_parser_unit.sv
src/wsmp_checker.sv
verif/tb.sv
